[design/pcs_pkg.sv]
// pcs_pkg: shared constants, register codes and the log2 / exp2 tables
// of the power curve shaper. Depends on nothing; used by pcs_lerp and
// power_curve_shaper.
package pcs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TAB_DEPTH = 256;
	localparam int IDX_W     = $clog2(TAB_DEPTH);
	localparam int TIDX_W    = $clog2(TAB_DEPTH + 1);
	localparam int SAMPLE_W  = FRAC_BITS + 1;
	localparam int ENTRY_W   = FRAC_BITS + 2;
	localparam int K_W       = 24;
	localparam int K_FRAC    = 16;
	localparam int SH_W      = $clog2(FRAC_BITS) + 1;
	localparam int NEG_W     = FRAC_BITS + SH_W;
	localparam int PROD_W    = NEG_W + K_W;
	localparam int E_W       = PROD_W - K_FRAC;
	localparam int N_W       = E_W - FRAC_BITS;
	localparam int LERP_W    = ENTRY_W + FRAC_BITS;

	localparam logic [SAMPLE_W-1:0] ONE = SAMPLE_W'(1) << FRAC_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = K_W;
	localparam logic [CFG_IDX_W-1:0] REG_SYMMETRY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

	// symmetry modes
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_POINT = 2'd1;
	localparam logic [1:0] MODE_AXIS  = 2'd2;

	localparam logic [K_W-1:0] K_RESET = 24'd131072;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [TAB_DEPTH:0][ENTRY_W-1:0] tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] arg);
		logic [63:0] a;
		logic [63:0] res;
		logic [63:0] bt;
		a   = arg;
		res = 64'd0;
		for (int q = 31; q >= 0; q--) begin
			bt = 64'd1 << (2 * q);
			if (a >= res + bt) begin
				a   = a - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	function automatic entry_t round_q30(input logic [63:0] v);
		logic [63:0] t;
		t = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		return ENTRY_W'(t);
	endfunction

	// Elaboration-time build of both tables. Log2 by repeated squaring,
	// exp2 as a product of successive square roots of two; built in Q30, stored in Q2.16.
	function automatic tab_t build_tab(input logic want_exp);
		tab_t        tab;
		logic [63:0] fac [0:30];
		logic [63:0] m;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] a;
		logic [63:0] q30;
		q30 = 64'd1 << 30;
		fac[0] = q30 << 1;
		for (int j = 1; j <= 30; j++) begin
			fac[j] = isqrt64(fac[j-1] << 30);
		end
		for (int i = 0; i < TAB_DEPTH; i++) begin
			t = (64'(i) << 30) / TAB_DEPTH;
			m = q30 + t;
			y = 64'd0;
			a = q30;
			for (int j = 1; j <= 30; j++) begin
				m = (m * m) >> 30;
				if (m >= (q30 << 1)) begin
					m = m >> 1;
					y = y + (64'd1 << (30 - j));
				end
				if (t[30-j]) begin
					a = (a * fac[j]) >> 30;
				end
			end
			tab[i] = want_exp ? round_q30(a) : round_q30(y);
		end
		tab[TAB_DEPTH] = want_exp ? (ENTRY_W'(1) << (FRAC_BITS + 1))
		                          : (ENTRY_W'(1) << FRAC_BITS);
		return tab;
	endfunction

	localparam tab_t LOG_TAB = build_tab(1'b0);
	localparam tab_t EXP_TAB = build_tab(1'b1);

endpackage

[design/power_curve_shaper.sv]
// power_curve_shaper: five-stage power-law waveshaper, y = base^k via
// exp2(k*log2(base)) with interpolated tables. Depends on pcs_pkg, pcs_lerp.
//
//  channel | direction | signals                          | beat
//  in      | sink      | in_valid in_ready sample_in      | one sample x
//  out     | source    | out_valid out_ready sample_out   | one shaped sample y
//  cfg     | sink      | cfg_valid cfg_ready cfg_index    | one register write
//          |           | cfg_data                         |
//
// One sample per cycle sustained while out_ready is high.
// Stages: normalize, log2 lookup, multiply by k, exp2 lookup, final shift and
// symmetry; the s5 register is the output register.
// Reset clears valid bits and the configuration registers (mode none, k = 2.0).
// Each stage holds while the one after it is full and stalled; bubbles close
// up, so in_ready drops only when every stage is full and out_ready is low.
// cfg_ready is always high.
module power_curve_shaper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pcs_pkg::SAMPLE_W-1:0]      sample_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pcs_pkg::SAMPLE_W-1:0]      sample_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int F  = pcs_pkg::FRAC_BITS;
	localparam int SW = pcs_pkg::SAMPLE_W;

	typedef struct packed {
		logic zero;
		logic one;
		logic below;
	} flags_t;

	// configuration
	logic [1:0]              mode_q;
	logic [pcs_pkg::K_W-1:0] k_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pcs_pkg::MODE_NONE;
			k_q    <= pcs_pkg::K_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcs_pkg::REG_SYMMETRY: mode_q <= cfg_data[1:0];
				pcs_pkg::REG_EXPONENT: k_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic sym;
	assign sym = (mode_q == pcs_pkg::MODE_POINT) || (mode_q == pcs_pkg::MODE_AXIS);

	// stage enables, back to front
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// ---- stage 1: clamp, fold, normalize
	logic [SW-1:0]            x;
	logic [SW:0]              x2;
	logic                     below;
	logic [SW:0]              span;
	logic [SW-1:0]            base;
	logic [$clog2(F)-1:0]     lead;
	logic [pcs_pkg::SH_W-1:0] sh;
	logic [2*F-1:0]           norm;

	assign x     = (sample_in > pcs_pkg::ONE) ? pcs_pkg::ONE : sample_in;
	assign x2    = {x, 1'b0};
	assign below = x2 < (SW+1)'(pcs_pkg::ONE);
	assign span  = below ? ((SW+1)'(pcs_pkg::ONE) - x2) : (x2 - (SW+1)'(pcs_pkg::ONE));

	always_comb begin
		if (sym) begin
			base = (span > (SW+1)'(pcs_pkg::ONE)) ? pcs_pkg::ONE : SW'(span);
		end else begin
			base = x;
		end
	end

	always_comb begin
		lead = '0;
		for (int b = 0; b < F; b++) begin
			if (base[b]) lead = ($clog2(F))'(b);
		end
	end

	assign sh   = pcs_pkg::SH_W'(F) - pcs_pkg::SH_W'(lead);
	assign norm = (2*F)'(base[F-1:0]) << sh;

	logic [F-1:0]             frac_s1;
	logic [pcs_pkg::SH_W-1:0] sh_s1;
	flags_t                   fl_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			frac_s1     <= norm[F-1:0];
			sh_s1       <= sh;
			fl_s1.zero  <= (base == '0);
			fl_s1.one   <= base[F];
			fl_s1.below <= below;
		end
	end

	// ---- stage 2: log2 of mantissa, negated log of base
	logic [pcs_pkg::IDX_W-1:0]  lidx;
	logic [pcs_pkg::TIDX_W-1:0] la, lb;
	logic [F-1:0]               lfr;
	pcs_pkg::entry_t            lval;
	logic [pcs_pkg::NEG_W-1:0]  neg;

	assign lidx = frac_s1[F-1 -: pcs_pkg::IDX_W];
	assign lfr  = frac_s1 << pcs_pkg::IDX_W;
	assign la   = pcs_pkg::TIDX_W'(lidx);
	assign lb   = pcs_pkg::TIDX_W'(lidx) + 1'b1;

	pcs_lerp u_log_lerp (
		.lo    (pcs_pkg::LOG_TAB[la]),
		.hi    (pcs_pkg::LOG_TAB[lb]),
		.frac  (lfr),
		.value (lval)
	);

	assign neg = (pcs_pkg::NEG_W'(sh_s1) << F) - pcs_pkg::NEG_W'(lval);

	logic [pcs_pkg::NEG_W-1:0] neg_s2;
	flags_t                    fl_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2 <= neg;
			fl_s2  <= fl_s1;
		end
	end

	// ---- stage 3: scale by k, round half up
	logic [pcs_pkg::PROD_W-1:0] prod;

	assign prod = pcs_pkg::PROD_W'(neg_s2) * pcs_pkg::PROD_W'(k_q)
	            + (pcs_pkg::PROD_W'(1) << (pcs_pkg::K_FRAC - 1));

	logic [pcs_pkg::E_W-1:0] e_s3;
	flags_t                  fl_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			e_s3  <= prod[pcs_pkg::PROD_W-1:pcs_pkg::K_FRAC];
			fl_s3 <= fl_s2;
		end
	end

	// ---- stage 4: exp2 of one minus the fraction
	logic [F-1:0]               rpart;
	logic [F-1:0]               epos;
	logic [pcs_pkg::IDX_W-1:0]  eidx;
	logic [pcs_pkg::TIDX_W-1:0] ea, eb;
	logic [F-1:0]               efr;
	pcs_pkg::entry_t            eval_v;

	assign rpart = e_s3[F-1:0];
	assign epos  = F'(pcs_pkg::ONE - SW'(rpart));
	assign eidx  = epos[F-1 -: pcs_pkg::IDX_W];
	assign efr   = epos << pcs_pkg::IDX_W;
	assign ea    = pcs_pkg::TIDX_W'(eidx);
	assign eb    = pcs_pkg::TIDX_W'(eidx) + 1'b1;

	pcs_lerp u_exp_lerp (
		.lo    (pcs_pkg::EXP_TAB[ea]),
		.hi    (pcs_pkg::EXP_TAB[eb]),
		.frac  (efr),
		.value (eval_v)
	);

	pcs_pkg::entry_t         ev_s4;
	logic [pcs_pkg::N_W-1:0] n_s4;
	logic                    rz_s4;
	flags_t                  fl_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ev_s4 <= eval_v;
			n_s4  <= e_s3[pcs_pkg::E_W-1:F];
			rz_s4 <= (rpart == '0);
			fl_s4 <= fl_s3;
		end
	end

	// ---- stage 5: final shift, saturation, symmetry
	logic [pcs_pkg::SH_W-1:0] nsh;
	logic [pcs_pkg::ENTRY_W:0] rsum;
	logic [pcs_pkg::ENTRY_W:0] rnd;
	logic [SW-1:0]            pw;
	logic [SW:0]              half;
	logic [SW:0]              ysel;
	logic [SW-1:0]            y;

	assign nsh  = n_s4[pcs_pkg::SH_W-1:0];
	assign rsum = (pcs_pkg::ENTRY_W+1)'(ev_s4) + ((pcs_pkg::ENTRY_W+1)'(1) << nsh);
	assign rnd  = rsum >> (nsh + 1'b1);

	always_comb begin
		priority if (fl_s4.zero) begin
			pw = '0;
		end else if (fl_s4.one) begin
			pw = pcs_pkg::ONE;
		end else if (rz_s4) begin
			pw = (n_s4 > pcs_pkg::N_W'(F)) ? '0 : (pcs_pkg::ONE >> nsh);
		end else if (n_s4 > pcs_pkg::N_W'(F + 1)) begin
			pw = '0;
		end else begin
			pw = (rnd > (pcs_pkg::ENTRY_W+1)'(pcs_pkg::ONE)) ? pcs_pkg::ONE : SW'(rnd);
		end
	end

	always_comb begin
		if (fl_s4.below) begin
			half = (SW+1)'(pcs_pkg::ONE - pw) + 1'b1;
		end else begin
			half = (SW+1)'(pcs_pkg::ONE) + (SW+1)'(pw) + 1'b1;
		end
		if (mode_q == pcs_pkg::MODE_POINT) begin
			ysel = half >> 1;
		end else begin
			ysel = (SW+1)'(pw);
		end
		y = (ysel > (SW+1)'(pcs_pkg::ONE)) ? pcs_pkg::ONE : SW'(ysel);
	end

	logic [SW-1:0] y_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			y_s5 <= y;
		end
	end

	assign out_valid  = v_s5;
	assign sample_out = y_s5;

	// ---- checks
	a_out_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_out <= pcs_pkg::ONE)
		else $error("output above one");

	a_neg_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> neg_s2 <= (pcs_pkg::NEG_W'(F) << F))
		else $error("log magnitude out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready))
		else $error("input stalled with a bubble in the pipe");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en_s4) |=> (v_s4 && $stable(ev_s4) && $stable(n_s4)))
		else $error("stalled exp stage changed");

endmodule

[design/pcs_lerp.sv]
// pcs_lerp: linear interpolation between two adjacent table entries, with
// the step from lo truncated to the fraction width. Depends on pcs_pkg.
module pcs_lerp (
	input  pcs_pkg::entry_t                   lo,
	input  pcs_pkg::entry_t                   hi,
	input  logic [pcs_pkg::FRAC_BITS-1:0]     frac,
	output pcs_pkg::entry_t                   value
);

	pcs_pkg::entry_t                    diff;
	logic [pcs_pkg::LERP_W-1:0]         prod;
	pcs_pkg::entry_t                    step;
	logic                               rising;

	assign rising = (hi >= lo);
	assign diff   = rising ? (hi - lo) : (lo - hi);
	assign prod   = pcs_pkg::LERP_W'(diff) * pcs_pkg::LERP_W'(frac);
	assign step   = pcs_pkg::ENTRY_W'(prod >> pcs_pkg::FRAC_BITS);
	assign value  = rising ? (lo + step) : (lo - step);

endmodule

[sim/tb_power_curve_shaper.sv]
// tb_power_curve_shaper: self-checking bench for power_curve_shaper. Streams samples
// with random idling on both sides, writes registers between runs and checks each
// shaped sample in order against an in-bench predictor. Depends on pcs_pkg and the RTL.
module tb_power_curve_shaper;
	import pcs_pkg::*;

	localparam int FB          = 16;
	localparam int K_FB        = 16;
	localparam int LUT_DEPTH   = 256;
	localparam logic [63:0] UNITY     = 64'd1 << FB;
	localparam logic [63:0] FRAC_MASK = UNITY - 64'd1;
	localparam logic [63:0] Q30_ONE   = 64'd1 << 30;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [K_W-1:0] K_DEFAULT = 24'd131072;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_MAX   = 50;

	typedef struct {
		logic [SAMPLE_W-1:0] x;
		logic [1:0]          mode;
		logic [K_W-1:0]      k;
		logic [SAMPLE_W-1:0] y;
	} shaped_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   sample_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SAMPLE_W-1:0]   sample_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// bench copy of the registers
	logic [1:0]     mode_m = MODE_NONE;
	logic [K_W-1:0] k_m    = K_DEFAULT;

	logic [63:0] log2_lut [0:LUT_DEPTH];
	logic [63:0] exp2_lut [0:LUT_DEPTH];

	logic [SAMPLE_W-1:0]             feed_q [$];
	logic [CFG_IDX_W+CFG_DATA_W-1:0] write_q [$];
	shaped_t                         shaped_q [$];
	shaped_t                         head;

	int queued_n    = 0;
	int checked_n   = 0;
	int writes_n    = 0;
	int writes_done = 0;
	int mismatch_n  = 0;
	int cycle_n     = 0;
	int tx_gap      = 0;
	int tx_steady   = 0;
	int rx_gap      = 0;
	int rx_steady   = 0;
	int rx_pick     = 0;
	int hold_req    = 0;
	int hold_seen   = 0;
	int hold_left   = 0;

	power_curve_shaper dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// log2(1+i/N) by repeated squaring, 2^(i/N) as a product of roots of two
	initial begin : lut_build
		logic [63:0] root2 [0:30];
		logic [63:0] acc, root, trial, m, t, lg, ex;
		root2[0] = Q30_ONE << 1;
		for (int j = 1; j <= 30; j++) begin
			acc  = root2[j-1] << 30;
			root = 64'd0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= acc)
					root = trial;
			end
			root2[j] = root;
		end
		for (int i = 0; i < LUT_DEPTH; i++) begin
			t  = (64'(i) << 30) / 64'(LUT_DEPTH);
			m  = Q30_ONE + t;
			lg = 64'd0;
			ex = Q30_ONE;
			for (int j = 1; j <= 30; j++) begin
				m = (m * m) >> 30;
				if (m >= (Q30_ONE << 1)) begin
					m  = m >> 1;
					lg = lg + (64'd1 << (30 - j));
				end
				if (t[30-j])
					ex = (ex * root2[j]) >> 30;
			end
			log2_lut[i] = (lg + (64'd1 << (29 - FB))) >> (30 - FB);
			exp2_lut[i] = (ex + (64'd1 << (29 - FB))) >> (30 - FB);
		end
		log2_lut[LUT_DEPTH] = UNITY;
		exp2_lut[LUT_DEPTH] = UNITY << 1;
	end

	function automatic logic [63:0] table_lerp(input logic use_exp, input logic [63:0] s);
		logic [63:0] pos, idx, fr, lo, hi;
		pos = (s & FRAC_MASK) * 64'(LUT_DEPTH);
		idx = pos >> FB;
		fr  = pos & FRAC_MASK;
		if (idx >= 64'(LUT_DEPTH))
			idx = 64'(LUT_DEPTH - 1);
		lo = use_exp ? exp2_lut[idx] : log2_lut[idx];
		hi = use_exp ? exp2_lut[idx+1] : log2_lut[idx+1];
		if (hi >= lo)
			return lo + (((hi - lo) * fr) >> FB);
		return lo - (((lo - hi) * fr) >> FB);
	endfunction

	// base^k for base in [0,1], as 2^-(k * -log2(base))
	function automatic logic [63:0] curve_power(input logic [63:0] base, input logic [K_W-1:0] k);
		logic [63:0] frac, neg, e, n, r, v;
		int msb;
		if (base == 64'd0)
			return 64'd0;
		if (base >= UNITY)
			return UNITY;
		msb = FB - 1;
		while (msb > 0 && !base[msb])
			msb--;
		frac = (base << (FB - msb)) - UNITY;
		neg  = (64'(FB - msb) << FB) - table_lerp(1'b0, frac);
		e    = (neg * 64'(k) + (64'd1 << (K_FB - 1))) >> K_FB;
		n    = e >> FB;
		r    = e & FRAC_MASK;
		if (r == 64'd0)
			return (n > 64'(FB)) ? 64'd0 : (UNITY >> n);
		if (n > 64'(FB + 1))
			return 64'd0;
		v = table_lerp(1'b1, UNITY - r);
		v = (v + (64'd1 << n)) >> (n + 64'd1);
		return (v > UNITY) ? UNITY : v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] shape_sample(input logic [SAMPLE_W-1:0] x,
		input logic [1:0] mode, input logic [K_W-1:0] k);
		logic [63:0] xv, d, p, y;
		logic below;
		xv = 64'(x);
		if (xv > UNITY)
			xv = UNITY;
		if (mode == MODE_POINT || mode == MODE_AXIS) begin
			below = (xv << 1) < UNITY;
			d = below ? UNITY - (xv << 1) : (xv << 1) - UNITY;
			p = curve_power((d > UNITY) ? UNITY : d, k);
			if (mode == MODE_AXIS)
				y = p;
			else if (below)
				y = (UNITY - p + 64'd1) >> 1;
			else
				y = (UNITY + p + 64'd1) >> 1;
		end else begin
			y = curve_power(xv, k);
		end
		if (y > UNITY)
			y = UNITY;
		return y[SAMPLE_W-1:0];
	endfunction

	// mostly short gaps, a few long ones, and now and then a run with none
	function automatic int pick_gap(inout int steady);
		int r;
		if (steady > 0) begin
			steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			steady = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_n++;
		if (mismatch_n <= PRINT_MAX)
			$display("MISMATCH cycle %0d: %s", cycle_n, what);
	endtask

	// sample driver; the prediction is taken when a beat is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			sample_in <= '0;
			tx_gap    <= 0;
		end else begin
			if (in_valid && in_ready)
				shaped_q.push_back('{sample_in, mode_m, k_m,
					shape_sample(sample_in, mode_m, k_m)});
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap   <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (feed_q.size() > 0) begin
					in_valid  <= 1'b1;
					sample_in <= feed_q.pop_front();
					tx_gap    <= pick_gap(tx_steady);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// register write driver, keeps the bench copy in step
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
			mode_m    <= MODE_NONE;
			k_m       <= K_DEFAULT;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SYMMETRY: mode_m <= cfg_data[1:0];
					REG_EXPONENT: k_m <= cfg_data;
					default: ;
				endcase
				writes_done <= writes_done + 1;
			end
			if (!cfg_valid || cfg_ready) begin
				if (write_q.size() > 0) begin
					cfg_valid              <= 1'b1;
					{cfg_index, cfg_data}  <= write_q.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver stall, started on request from the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (shaped_q.size() == 0) begin
					report_mismatch($sformatf("beat 0x%05h with no sample pending", sample_out));
				end else begin
					head = shaped_q.pop_front();
					checked_n++;
					if (sample_out !== head.y)
						report_mismatch($sformatf(
							"x=0x%05h mode=%0d k=0x%06h: got 0x%05h, predicted 0x%05h",
							head.x, head.mode, head.k, sample_out, head.y));
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap    <= rx_gap - 1;
			end else if (!out_ready) begin
				out_ready <= 1'b1;
			end else if (out_valid) begin
				rx_pick = pick_gap(rx_steady);
				out_ready <= (rx_pick == 0);
				rx_gap    <= (rx_pick == 0) ? 0 : rx_pick - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("power_curve_shaper regression: fail");
			$finish;
		end
	end

	task automatic offer(input logic [SAMPLE_W-1:0] x);
		feed_q.push_back(x);
		queued_n++;
	endtask

	task automatic settle();
		while (checked_n != queued_n)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		write_q.push_back({idx, data});
		writes_n++;
		while (writes_done != writes_n)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic [SAMPLE_W-1:0] x;
		logic [K_W-1:0]      kv;
		logic [1:0]          mv;
		int                  sh;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: plain curve, k = 2.0; extremes and inputs above one
		offer(17'h00000);
		offer(17'h00001);
		offer(17'h00100);
		offer(17'h08000);
		offer(17'h0FFFF);
		offer(17'h10000);
		offer(17'h10001);
		offer(17'h1FFFF);
		settle();

		// point symmetry, k = 0.5: center gives base zero
		write_reg(REG_SYMMETRY, {22'($urandom), MODE_POINT});
		write_reg(REG_EXPONENT, 24'h008000);
		offer(17'h08000);
		offer(17'h07FFF);
		offer(17'h08001);
		offer(17'h00000);
		offer(17'h10000);
		settle();

		// axis symmetry with zero exponent
		write_reg(REG_SYMMETRY, {22'($urandom), MODE_AXIS});
		write_reg(REG_EXPONENT, 24'h000000);
		offer(17'h08000);
		offer(17'h04000);
		offer(17'h1FFFF);
		settle();

		// spare mode behaves as plain; largest k drives powers to underflow
		write_reg(REG_SYMMETRY, {22'($urandom), MODE_SPARE});
		write_reg(REG_EXPONENT, 24'hFFFFFF);
		offer(17'h00001);
		offer(17'h0FFFF);
		offer(17'h0C000);
		settle();

		// writes to unused indexes must change nothing; smallest nonzero k
		write_reg(REG_SPARE_A, 24'($urandom));
		write_reg(REG_SPARE_B, 24'($urandom));
		write_reg(REG_EXPONENT, 24'd1);
		offer(17'h00001);
		offer(17'h0ABCD);
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			mv = 2'($urandom_range(0, 3));
			sh = $urandom_range(8, 22);
			case ($urandom_range(0, 9))
				0: kv = 24'hFFFFFF;
				1: kv = 24'($urandom_range(0, 15));
				2, 3: kv = 24'($urandom);
				default: kv = $urandom_range(0, 1) ? 24'(1 << sh)
					: 24'($urandom_range(1 << sh, (2 << sh) - 1));
			endcase
			write_reg(REG_SYMMETRY, {22'($urandom), mv});
			write_reg(REG_EXPONENT, kv);
			for (int i = 0; i < 50; i++) begin
				case ($urandom_range(0, 9))
					0: x = 17'($urandom_range(0, 17'h1FFFF));
					1: x = 17'($urandom_range(0, 255));
					2: x = 17'(17'h07F00 + $urandom_range(0, 511));
					3: x = 17'(17'h10000 - $urandom_range(0, 255));
					default: x = 17'($urandom_range(0, 17'h10000));
				endcase
				offer(x);
			end
			// stall the output while samples keep coming so the pipe backs up
			if (ph == 1 || ph == 6) begin
				@(negedge clk);
				hold_req++;
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_n == 0)
			$display("power_curve_shaper regression: pass");
		else
			$display("power_curve_shaper regression: fail");
		$finish;
	end

endmodule
